@@ sv/iis_pkg.sv @@
package iis_pkg;

  localparam int DEF_MAX_WIDTH  = 2048;
  localparam int DEF_MAX_HEIGHT = 2048;

  localparam int PIX_W   = 8;
  localparam int SUM_W   = 30;
  localparam int SQSUM_W = 38;
  localparam int CFG_W   = 12;
  localparam int IDX_W   = 4;

  localparam logic [IDX_W-1:0] REG_FRAME_WIDTH  = IDX_W'(0);
  localparam logic [IDX_W-1:0] REG_FRAME_HEIGHT = IDX_W'(1);

  localparam logic [CFG_W-1:0] DIM_RESET = CFG_W'(2048);

  typedef struct packed {
    logic row_first;
    logic row_end;
    logic frame_end;
  } pos_flags_t;

  // Last valid index for a dimension register: zero acts as one, large values saturate.
  function automatic int clamp_last(input logic [CFG_W-1:0] v, input int maxv);
    int r;
    if (v == '0) begin
      r = 0;
    end else if (int'(v) > maxv) begin
      r = maxv - 1;
    end else begin
      r = int'(v) - 1;
    end
    return r;
  endfunction

endpackage

@@ sv/iis_pix_if.sv @@
interface iis_pix_if;
  logic                     valid;
  logic                     ready;
  logic [iis_pkg::PIX_W-1:0] pixel;

  modport source (output valid, output pixel, input ready);
  modport sink (input valid, input pixel, output ready);
endinterface

@@ sv/iis_res_if.sv @@
interface iis_res_if;
  logic                       valid;
  logic                       ready;
  logic [iis_pkg::SUM_W-1:0]   integral_sum;
  logic [iis_pkg::SQSUM_W-1:0] integral_sqsum;
  logic                       row_end;
  logic                       frame_end;

  modport source (output valid, output integral_sum, output integral_sqsum,
                  output row_end, output frame_end, input ready);
  modport sink (input valid, input integral_sum, input integral_sqsum,
                input row_end, input frame_end, output ready);
endinterface

@@ sv/iis_cfg_if.sv @@
interface iis_cfg_if;
  logic                     valid;
  logic                     ready;
  logic [iis_pkg::IDX_W-1:0] index;
  logic [iis_pkg::CFG_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

@@ sv/iis_line_buf.sv @@
module iis_line_buf #(
  parameter int DEPTH = 2048,
  parameter int AW    = 11,
  parameter int DW    = 68
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Write-first: a read of the entry being written this cycle sees the new data.
  always_ff @(posedge clk) begin
    if (re) begin
      if (we && (waddr == raddr)) begin
        rdata <= wdata;
      end else begin
        rdata <= mem[raddr];
      end
    end
  end

endmodule

@@ sv/iis_ctrl.sv @@
module iis_ctrl #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048,
  parameter int CW         = 11,
  parameter int RW         = 11,
  parameter int RSW        = 19,
  parameter int RQW        = 27
) (
  input  logic                       clk,
  input  logic                       rst,
  iis_cfg_if.sink                    cfg,
  input  logic                       accept,
  input  logic [iis_pkg::PIX_W-1:0]  pixel,
  output logic [CW-1:0]              col,
  output iis_pkg::pos_flags_t        flags,
  output logic [RSW-1:0]             sum_now,
  output logic [RQW-1:0]             sq_now
);
  import iis_pkg::*;

  logic [CW-1:0]  col_cnt;
  logic [RW-1:0]  row_cnt;
  logic [RSW-1:0] run_sum;
  logic [RQW-1:0] run_sq;
  logic [CW-1:0]  w_last;
  logic [RW-1:0]  h_last;
  logic [2*PIX_W-1:0] pix_sq;
  logic           cfg_wr;

  assign cfg.ready = 1'b1;
  assign cfg_wr    = cfg.valid && cfg.ready;

  assign pix_sq          = pixel * pixel;
  assign sum_now         = run_sum + RSW'(pixel);
  assign sq_now          = run_sq + RQW'(pix_sq);
  assign col             = col_cnt;
  assign flags.row_first = (row_cnt == '0);
  assign flags.row_end   = (col_cnt == w_last);
  assign flags.frame_end = flags.row_end && (row_cnt == h_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      col_cnt <= '0;
      row_cnt <= '0;
      run_sum <= '0;
      run_sq  <= '0;
      w_last  <= CW'(clamp_last(DIM_RESET, MAX_WIDTH));
      h_last  <= RW'(clamp_last(DIM_RESET, MAX_HEIGHT));
    end else if (cfg_wr) begin
      if (cfg.index == REG_FRAME_WIDTH || cfg.index == REG_FRAME_HEIGHT) begin
        // restart the plane on any dimension write
        col_cnt <= '0;
        row_cnt <= '0;
        run_sum <= '0;
        run_sq  <= '0;
      end
      if (cfg.index == REG_FRAME_WIDTH) begin
        w_last <= CW'(clamp_last(cfg.data, MAX_WIDTH));
      end
      if (cfg.index == REG_FRAME_HEIGHT) begin
        h_last <= RW'(clamp_last(cfg.data, MAX_HEIGHT));
      end
    end else if (accept) begin
      if (flags.row_end) begin
        col_cnt <= '0;
        run_sum <= '0;
        run_sq  <= '0;
        row_cnt <= flags.frame_end ? '0 : row_cnt + RW'(1);
      end else begin
        col_cnt <= col_cnt + CW'(1);
        run_sum <= sum_now;
        run_sq  <= sq_now;
      end
    end
  end

endmodule

@@ sv/integral_image_sum_sqsum_core.sv @@
// Path: an accepted pixel request is registered in the read stage, then in the output register that drives the result.
// Throughput: one pixel per cycle sustained while res.ready holds; the row running sum closes in a single
// adder loop and the line buffer is a one-read, one-write memory with write-first bypass.
// Reset: position and row sums clear, frame width and height return to 2048
// (saturated to the maximums); the line buffer is not cleared and needs no pass.
module integral_image_sum_sqsum_core #(
  parameter int MAX_WIDTH  = iis_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = iis_pkg::DEF_MAX_HEIGHT
) (
  input  logic      clk,
  input  logic      rst,
  iis_pix_if.sink   pix,
  iis_res_if.source res,
  iis_cfg_if.sink   cfg
);
  import iis_pkg::*;

  localparam int CW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int RW  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int RSW = PIX_W + CW;
  localparam int RQW = 2 * PIX_W + CW;
  localparam int LDW = SUM_W + SQSUM_W;

  logic [CW-1:0]  c_col;
  pos_flags_t     c_flags;
  logic [RSW-1:0] c_sum;
  logic [RQW-1:0] c_sq;
  logic           accept;

  logic           s1_valid;
  logic [CW-1:0]  s1_col;
  pos_flags_t     s1_flags;
  logic [RSW-1:0] s1_sum;
  logic [RQW-1:0] s1_sq;
  logic           s1_go;

  logic [LDW-1:0]     lb_rdata;
  logic [SUM_W-1:0]   above_sum;
  logic [SQSUM_W-1:0] above_sq;
  logic [SUM_W-1:0]   tot_sum;
  logic [SQSUM_W-1:0] tot_sq;

  logic               out_valid;
  logic [SUM_W-1:0]   out_sum;
  logic [SQSUM_W-1:0] out_sq;
  logic               out_row_end;
  logic               out_frame_end;

  assign s1_go     = s1_valid && (!out_valid || res.ready);
  assign pix.ready = !s1_valid || s1_go;
  assign accept    = pix.valid && pix.ready;

  iis_ctrl #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .CW         (CW),
    .RW         (RW),
    .RSW        (RSW),
    .RQW        (RQW)
  ) u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .accept  (accept),
    .pixel   (pix.pixel),
    .col     (c_col),
    .flags   (c_flags),
    .sum_now (c_sum),
    .sq_now  (c_sq)
  );

  iis_line_buf #(
    .DEPTH (MAX_WIDTH),
    .AW    (CW),
    .DW    (LDW)
  ) u_line_buf (
    .clk   (clk),
    .we    (s1_go),
    .waddr (s1_col),
    .wdata ({tot_sum, tot_sq}),
    .re    (accept),
    .raddr (c_col),
    .rdata (lb_rdata)
  );

  // first row of a plane sees zero above
  assign above_sum = s1_flags.row_first ? '0 : lb_rdata[LDW-1 -: SUM_W];
  assign above_sq  = s1_flags.row_first ? '0 : lb_rdata[SQSUM_W-1:0];
  assign tot_sum   = above_sum + SUM_W'(s1_sum);
  assign tot_sq    = above_sq + SQSUM_W'(s1_sq);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_col   <= c_col;
      s1_flags <= c_flags;
      s1_sum   <= c_sum;
      s1_sq    <= c_sq;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_go) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      out_sum       <= tot_sum;
      out_sq        <= tot_sq;
      out_row_end   <= s1_flags.row_end;
      out_frame_end <= s1_flags.frame_end;
    end
  end

  assign res.valid          = out_valid;
  assign res.integral_sum   = out_sum;
  assign res.integral_sqsum = out_sq;
  assign res.row_end        = out_row_end;
  assign res.frame_end      = out_frame_end;

`ifndef ASSERT_OFF
  a_frame_end_row_end: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> (!res.frame_end || res.row_end))
    else $error("frame_end without row_end");

  a_accept_fills_s1: assert property (@(posedge clk) disable iff (rst)
    (pix.valid && pix.ready) |=> s1_valid)
    else $error("accepted request lost before read stage");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !s1_valid |-> pix.ready)
    else $error("input stalled with empty read stage");

  a_s1_drains: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !out_valid) |=> out_valid)
    else $error("read stage did not advance into empty output register");
`endif

endmodule

@@ tb/iis_integral_checker.sv @@
module iis_integral_checker #(
  parameter int MAX_WIDTH  = iis_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = iis_pkg::DEF_MAX_HEIGHT
) (
  input  logic clk,
  input  logic rst,
  iis_pix_if   pix,
  iis_res_if   res,
  iis_cfg_if   cfg,
  output int   errors,
  output int   in_flight,
  output int   planes_closed
);
  timeunit 1ns;
  timeprecision 1ps;
  import iis_pkg::*;

  typedef struct packed {
    logic [SUM_W-1:0]   sum;
    logic [SQSUM_W-1:0] sqsum;
    logic               row_end;
    logic               frame_end;
  } integral_t;

  logic [CFG_W-1:0]   width_reg;
  logic [CFG_W-1:0]   height_reg;
  logic [10:0]        col_pos;
  logic [10:0]        row_pos;
  logic [18:0]        row_acc;
  logic [26:0]        row_sq_acc;
  logic [SUM_W-1:0]   line_sum [MAX_WIDTH];
  logic [SQSUM_W-1:0] line_sq [MAX_WIDTH];
  integral_t          sums_due [$];

  // Zero acts as one, anything above the buffer size saturates.
  function automatic int live_dim(input logic [CFG_W-1:0] v, input int limit);
    if (v == '0) return 1;
    return (int'(v) > limit) ? limit : int'(v);
  endfunction

  task automatic restart_plane();
    col_pos    = '0;
    row_pos    = '0;
    row_acc    = '0;
    row_sq_acc = '0;
  endtask

  task automatic report_mismatch(input string what);
    errors++;
    if (errors <= 40) $display("[%0t] mismatch: %s", $time, what);
  endtask

  task automatic integrate_pixel(input logic [PIX_W-1:0] p);
    int                 w;
    int                 h;
    logic [15:0]        sq;
    logic [SUM_W-1:0]   above_s;
    logic [SQSUM_W-1:0] above_q;
    integral_t          r;
    w  = live_dim(width_reg, MAX_WIDTH);
    h  = live_dim(height_reg, MAX_HEIGHT);
    sq = p * p;
    row_acc    = row_acc + p;
    row_sq_acc = row_sq_acc + sq;
    // the first row of a plane sees zero above it
    above_s = (row_pos != '0) ? line_sum[col_pos] : '0;
    above_q = (row_pos != '0) ? line_sq[col_pos] : '0;
    r.sum   = above_s + row_acc;
    r.sqsum = above_q + row_sq_acc;
    line_sum[col_pos] = r.sum;
    line_sq[col_pos]  = r.sqsum;
    r.row_end   = (int'(col_pos) == w - 1);
    r.frame_end = r.row_end && (int'(row_pos) >= h - 1);
    if (r.row_end) begin
      col_pos    = '0;
      row_acc    = '0;
      row_sq_acc = '0;
      row_pos    = r.frame_end ? '0 : row_pos + 1'b1;
    end else begin
      col_pos = col_pos + 1'b1;
    end
    sums_due.push_back(r);
  endtask

  task automatic check_result();
    integral_t e;
    if (sums_due.size() == 0) begin
      report_mismatch($sformatf("result sum=%0d sqsum=%0d with no pixel waiting",
                                res.integral_sum, res.integral_sqsum));
      return;
    end
    e = sums_due.pop_front();
    if (res.integral_sum !== e.sum)
      report_mismatch($sformatf("integral_sum %0d, want %0d", res.integral_sum, e.sum));
    if (res.integral_sqsum !== e.sqsum)
      report_mismatch($sformatf("integral_sqsum %0d, want %0d", res.integral_sqsum, e.sqsum));
    if (res.row_end !== e.row_end)
      report_mismatch($sformatf("row_end %b, want %b", res.row_end, e.row_end));
    if (res.frame_end !== e.frame_end)
      report_mismatch($sformatf("frame_end %b, want %b", res.frame_end, e.frame_end));
    if (e.frame_end) planes_closed++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      width_reg  = DIM_RESET;
      height_reg = DIM_RESET;
      restart_plane();
      sums_due.delete();
    end else begin
      if (cfg.valid === 1'b1 && cfg.ready === 1'b1) begin
        case (cfg.index)
          REG_FRAME_WIDTH: begin
            width_reg = cfg.data;
            restart_plane();
          end
          REG_FRAME_HEIGHT: begin
            height_reg = cfg.data;
            restart_plane();
          end
          default: ;
        endcase
      end
      // retire before predicting so a stray result cannot match a fresh request
      if (res.valid === 1'b1 && res.ready === 1'b1) check_result();
      if (pix.valid === 1'b1 && pix.ready === 1'b1) integrate_pixel(pix.pixel);
    end
    in_flight = sums_due.size();
  end

endmodule

@@ tb/integral_image_sum_sqsum_core_tb.sv @@
module integral_image_sum_sqsum_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import iis_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int RANDOM_PIXELS = 760;

  typedef enum int {PIX_UNIFORM, PIX_BRIGHT, PIX_EXTREME, PIX_DIM} pixel_mix_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   cycle_count;
  int   errors;
  int   in_flight;
  int   planes_closed;
  int   burst_left;
  int   pixels_sent;
  int   dims_written;
  bit   hold_off_req;

  iis_pix_if pix_ch ();
  iis_res_if res_ch ();
  iis_cfg_if cfg_ch ();

  integral_image_sum_sqsum_core dut (
    .clk (clk),
    .rst (rst),
    .pix (pix_ch),
    .res (res_ch),
    .cfg (cfg_ch)
  );

  iis_integral_checker sums_check (
    .clk           (clk),
    .rst           (rst),
    .pix           (pix_ch),
    .res           (res_ch),
    .cfg           (cfg_ch),
    .errors        (errors),
    .in_flight     (in_flight),
    .planes_closed (planes_closed)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Output side: random stall modes, each held for a random span, plus long hold-offs.
  initial begin : result_sink
    int mode;
    int span;
    res_ch.ready = 1'b0;
    mode = 0;
    span = 0;
    @(negedge clk);
    forever begin
      if (hold_off_req) begin
        res_ch.ready <= 1'b0;
        repeat ($urandom_range(150, 400)) @(negedge clk);
        hold_off_req = 1'b0;
      end else begin
        if (span == 0) begin
          mode = $urandom_range(0, 3);
          span = $urandom_range(8, 64);
        end
        span--;
        case (mode)
          0:       res_ch.ready <= 1'b1;
          1:       res_ch.ready <= ($urandom_range(0, 1) == 0);
          2:       res_ch.ready <= ($urandom_range(0, 7) == 0);
          default: res_ch.ready <= ($urandom_range(0, 3) != 0);
        endcase
        @(negedge clk);
      end
    end
  end

  function automatic logic [PIX_W-1:0] pick_pixel(input pixel_mix_t mix);
    case (mix)
      PIX_BRIGHT:  return '1;
      PIX_EXTREME: return ($urandom_range(0, 1) == 0) ? '0 : '1;
      PIX_DIM:     return PIX_W'($urandom_range(0, 3));
      default:     return PIX_W'($urandom());
    endcase
  endfunction

  task automatic send_pixel(input logic [PIX_W-1:0] p);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        pix_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    pix_ch.valid <= 1'b1;
    pix_ch.pixel <= p;
    do @(posedge clk); while (pix_ch.ready !== 1'b1);
    @(negedge clk);
    burst_left--;
    pixels_sent++;
  endtask

  // Drop the request and hold until every result is back.
  task automatic drain();
    pix_ch.valid <= 1'b0;
    do @(negedge clk); while (in_flight != 0);
    burst_left = 0;
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_dims(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
    drain();
    write_reg(REG_FRAME_WIDTH, w);
    write_reg(REG_FRAME_HEIGHT, h);
    dims_written++;
  endtask

  initial begin : stimulus
    int         w;
    int         h;
    int         wn;
    int         hn;
    int         n;
    int         rand_pixels;
    int         phase;
    pixel_mix_t mix;
    pix_ch.valid = 1'b0;
    pix_ch.pixel = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data  = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // zero dimensions act as one: each pixel closes a plane
    set_dims('0, '0);
    send_pixel('1);
    send_pixel('0);
    send_pixel('1);
    set_dims(CFG_W'(3), CFG_W'(2));
    repeat (6) send_pixel('1);
    // saturated height, left partway; unknown indexes must not restart the plane
    set_dims(CFG_W'(2), '1);
    send_pixel('0);
    send_pixel('1);
    send_pixel(PIX_W'(8'h55));
    drain();
    write_reg(REG_FRAME_HEIGHT + IDX_W'(1), '1);
    write_reg('1, '0);
    send_pixel(PIX_W'(8'hAA));
    send_pixel(PIX_W'(8'h80));
    send_pixel(PIX_W'(8'h01));
    set_dims('1, CFG_W'(2));
    repeat (4) send_pixel(pick_pixel(PIX_UNIFORM));

    rand_pixels = 0;
    phase = 0;
    while (rand_pixels < RANDOM_PIXELS) begin
      case ($urandom_range(0, 9))
        0: begin
          w = $urandom_range(0, 1);
          h = $urandom_range(1, 6);
        end
        1: begin
          w = $urandom_range(1, 12);
          h = $urandom_range(0, 1);
        end
        2: begin
          w = $urandom_range(9, 24);
          h = $urandom_range(2, 5);
        end
        default: begin
          w = $urandom_range(1, 8);
          h = $urandom_range(1, 6);
        end
      endcase
      wn  = (w == 0) ? 1 : w;
      hn  = (h == 0) ? 1 : h;
      mix = pixel_mix_t'($urandom_range(0, 3));
      // mostly whole planes; the rest stop partway and get restarted by the next write
      if ($urandom_range(0, 4) != 0) n = $urandom_range(1, 3) * wn * hn;
      else n = $urandom_range(1, wn * hn + wn);
      if (phase == 1) begin
        w = 8;
        h = 8;
        n = 64;
      end
      set_dims(CFG_W'(w), CFG_W'(h));
      if ($urandom_range(0, 5) == 0)
        write_reg(REG_FRAME_HEIGHT + IDX_W'($urandom_range(1, 14)), CFG_W'($urandom()));
      if (phase == 1 || $urandom_range(0, 15) == 0) hold_off_req = 1'b1;
      for (int i = 0; i < n; i++) begin
        if ((phase == 2 && i == n / 2) || $urandom_range(0, 149) == 0) drain();
        send_pixel(pick_pixel(mix));
      end
      rand_pixels += n;
      phase++;
    end

    drain();
    repeat (8) @(negedge clk);
    $display("%0d pixels over %0d dimension settings, %0d planes closed",
             pixels_sent, dims_written, planes_closed);
    $display("dims zero to saturated, stray register writes, long output stalls");
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

@@ files.f @@
sv/iis_pkg.sv
sv/iis_pix_if.sv
sv/iis_res_if.sv
sv/iis_cfg_if.sv
sv/iis_line_buf.sv
sv/iis_ctrl.sv
sv/integral_image_sum_sqsum_core.sv
tb/iis_integral_checker.sv
tb/integral_image_sum_sqsum_core_tb.sv
